FILE: src/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies; include guard keeps a second include harmless
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is low
`define ESC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds through reset
`define ESC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/esc_pkg.sv
// shared types, codes and helpers for the elevator sweep controller
// no dependencies; imported by every module of the block
package esc_pkg;

    localparam int OP_W    = 2;
    localparam int FLOOR_W = 4;
    localparam int CFG_W   = 5;
    localparam int ACT_W   = 2;
    localparam int MODE_W  = 2;

    // request and tick codes
    localparam logic [OP_W-1:0] OP_UP_CALL   = 2'd0;
    localparam logic [OP_W-1:0] OP_DOWN_CALL = 2'd1;
    localparam logic [OP_W-1:0] OP_CAR_CALL  = 2'd2;
    localparam logic [OP_W-1:0] OP_TICK      = 2'd3;

    // result actions
    localparam logic [ACT_W-1:0] ACT_IDLE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DOOR = 2'd1;
    localparam logic [ACT_W-1:0] ACT_MOVE = 2'd2;
    localparam logic [ACT_W-1:0] ACT_TURN = 2'd3;

    // car modes
    localparam logic [MODE_W-1:0] MODE_STOP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UP   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DOWN = 2'd2;

    localparam logic [CFG_W-1:0] NUM_FLOORS_RESET = 5'd16;

    // queue depths between the parts
    localparam int IQ_DEPTH = 2;
    localparam int OQ_DEPTH = 2;

    typedef struct packed {
        logic               is_tick;
        logic [OP_W-1:0]    op;
        logic [FLOOR_W-1:0] floor;
    } t_item;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [FLOOR_W-1:0] car_floor;
        logic [MODE_W-1:0]  direction;
        logic               last;
    } t_result;

    function automatic t_result mk_result(input logic [ACT_W-1:0] act,
                                          input logic [FLOOR_W-1:0] fl,
                                          input logic [MODE_W-1:0] dir,
                                          input logic lst);
        t_result r;
        r.action    = act;
        r.car_floor = fl;
        r.direction = dir;
        r.last      = lst;
        return r;
    endfunction

endpackage

FILE: src/esc_front.sv
// front part: input queue that takes request and tick beats and tags ticks
// depends on esc_pkg
module esc_front
    import esc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic [OP_W-1:0]    i_op,
    input  logic [FLOOR_W-1:0] i_floor,
    output logic               o_valid,
    output t_item              o_item,
    input  logic               i_pop
);

    localparam int AW = (IQ_DEPTH > 1) ? $clog2(IQ_DEPTH) : 1;
    localparam int CW = $clog2(IQ_DEPTH + 1);

    t_item           r_mem [IQ_DEPTH];
    logic [AW-1:0]   r_wr, n_wr;
    logic [AW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            w_wen, w_ren;
    t_item           w_in;

    assign o_full  = (r_cnt == CW'(IQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign w_wen   = i_push && !o_full;
    assign w_ren   = i_pop && o_valid;

    always_comb begin
        w_in.is_tick = (i_op == OP_TICK);
        w_in.op      = i_op;
        w_in.floor   = i_floor;
    end

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_wen) begin
            n_wr = (r_wr == AW'(IQ_DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (w_ren) begin
            n_rd = (r_rd == AW'(IQ_DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (w_wen && !w_ren) begin
            n_cnt = r_cnt + CW'(1);
        end else if (!w_wen && w_ren) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wen) begin
            r_mem[r_wr] <= w_in;
        end
    end

endmodule

FILE: src/esc_outq.sv
// result queue between the back part and the result ports
// depends on esc_pkg
module esc_outq
    import esc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    output logic    o_full,
    output logic    o_empty,
    output t_result o_res,
    input  logic    i_pop
);

    localparam int AW = (OQ_DEPTH > 1) ? $clog2(OQ_DEPTH) : 1;
    localparam int CW = $clog2(OQ_DEPTH + 1);

    t_result       r_mem [OQ_DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          w_wen, w_ren;

    assign o_full  = (r_cnt == CW'(OQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_res   = r_mem[r_rd];
    assign w_wen   = i_push && !o_full;
    assign w_ren   = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_wen) begin
            n_wr = (r_wr == AW'(OQ_DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (w_ren) begin
            n_rd = (r_rd == AW'(OQ_DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (w_wen && !w_ren) begin
            n_cnt = r_cnt + CW'(1);
        end else if (!w_wen && w_ren) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wen) begin
            r_mem[r_wr] <= i_res;
        end
    end

endmodule

FILE: src/esc_back.sv
// back part: call bitmaps, car state, floor scan sequencer and sweep decision
// depends on esc_pkg; fed by esc_front, drains into esc_outq
module esc_back
    import esc_pkg::*;
#(
    parameter int FLOORS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_item_valid,
    input  t_item            i_item,
    output logic             o_item_pop,
    input  logic             i_res_full,
    output logic             o_res_push,
    output t_result          o_res
);

    localparam int PW = $clog2(FLOORS);
    localparam int NW = $clog2(FLOORS + 1);
    localparam int EW = (NW > CFG_W) ? NW : CFG_W;
    localparam int WC = PW + 1;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_EMIT0  = 3'd3;
    localparam logic [2:0] ST_EMIT1  = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [CFG_W-1:0]  r_num_floors;
    logic [FLOORS-1:0] r_up, n_up;
    logic [FLOORS-1:0] r_down, n_down;
    logic [FLOORS-1:0] r_car, n_car;
    logic [PW-1:0]     r_pos, n_pos;
    logic [MODE_W-1:0] r_mode, n_mode;
    logic              r_rev, n_rev;
    logic [PW-1:0]     r_cnt, n_cnt;
    logic              r_below, n_below;
    logic              r_at, n_at;
    logic              r_above, n_above;
    t_result           r_res0, n_res0;
    t_result           r_res1, n_res1;
    logic              r_two, n_two;

    logic [EW-1:0]     w_cfg_ext;
    logic [EW-1:0]     w_nf_ext;
    logic [WC-1:0]     w_nf_c;
    logic [WC-1:0]     w_pos_c;
    logic [FLOORS-1:0] w_pend;
    logic [FLOORS-1:0] w_fmask;
    logic [FLOORS-1:0] w_cmask;
    logic              w_floor_ok;
    logic              w_can_up;
    logic              w_can_dn;
    logic [PW-1:0]     w_pos_up;
    logic [PW-1:0]     w_pos_dn;
    logic [PW+3:0]     w_cf_cur_x;
    logic [PW+3:0]     w_cf_up_x;
    logic [PW+3:0]     w_cf_dn_x;
    logic [FLOOR_W-1:0] w_cf_cur;
    logic [FLOOR_W-1:0] w_cf_up;
    logic [FLOOR_W-1:0] w_cf_dn;
    logic              w_uc, w_dc, w_cc;

    assign o_cfg_ready = 1'b1;

    // effective floor count, clamped to two .. FLOORS
    always_comb begin
        w_cfg_ext = EW'(r_num_floors);
        if (w_cfg_ext < EW'(2)) begin
            w_nf_ext = EW'(2);
        end else if (w_cfg_ext > EW'(FLOORS)) begin
            w_nf_ext = EW'(FLOORS);
        end else begin
            w_nf_ext = w_cfg_ext;
        end
    end

    assign w_nf_c   = WC'(w_nf_ext[NW-1:0]);
    assign w_pos_c  = WC'(r_pos);
    assign w_pend   = r_up | r_down | r_car;
    assign w_can_up = (w_pos_c + WC'(1)) < w_nf_c;
    assign w_can_dn = (r_pos != '0);
    assign w_pos_up = r_pos + PW'(1);
    assign w_pos_dn = r_pos - PW'(1);
    assign w_cmask  = FLOORS'(1) << r_pos;
    assign w_uc     = r_up[r_pos];
    assign w_dc     = r_down[r_pos];
    assign w_cc     = r_car[r_pos];
    assign w_floor_ok = EW'(i_item.floor) < w_nf_ext;

    assign w_cf_cur_x = {4'b0000, r_pos};
    assign w_cf_up_x  = {4'b0000, w_pos_up};
    assign w_cf_dn_x  = {4'b0000, w_pos_dn};
    assign w_cf_cur   = w_cf_cur_x[FLOOR_W-1:0];
    assign w_cf_up    = w_cf_up_x[FLOOR_W-1:0];
    assign w_cf_dn    = w_cf_dn_x[FLOOR_W-1:0];

    always_comb begin
        for (int i = 0; i < FLOORS; i++) begin
            w_fmask[i] = (EW'(i_item.floor) == EW'(i));
        end
    end

    always_comb begin
        n_state    = r_state;
        n_up       = r_up;
        n_down     = r_down;
        n_car      = r_car;
        n_pos      = r_pos;
        n_mode     = r_mode;
        n_rev      = r_rev;
        n_cnt      = r_cnt;
        n_below    = r_below;
        n_at       = r_at;
        n_above    = r_above;
        n_res0     = r_res0;
        n_res1     = r_res1;
        n_two      = r_two;
        o_item_pop = 1'b0;
        o_res_push = 1'b0;
        o_res      = (r_state == ST_EMIT1) ? r_res1 : r_res0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_item_valid) begin
                    o_item_pop = 1'b1;
                    if (i_item.is_tick) begin
                        n_cnt   = '0;
                        n_below = 1'b0;
                        n_at    = 1'b0;
                        n_above = 1'b0;
                        n_state = ST_SCAN;
                    end else begin
                        if (w_floor_ok) begin
                            unique case (i_item.op)
                                OP_UP_CALL:   n_up   = r_up | w_fmask;
                                OP_DOWN_CALL: n_down = r_down | w_fmask;
                                OP_CAR_CALL:  n_car  = r_car | w_fmask;
                                OP_TICK:      n_car  = r_car;
                            endcase
                        end
                        n_res0  = mk_result(ACT_IDLE, w_cf_cur, r_mode, 1'b1);
                        n_two   = 1'b0;
                        n_state = ST_EMIT0;
                    end
                end
            end

            // one floor per cycle: pending calls below, at and above the car
            ST_SCAN: begin
                if (w_pend[r_cnt]) begin
                    if (r_cnt < r_pos) begin
                        n_below = 1'b1;
                    end else if (r_cnt == r_pos) begin
                        n_at = 1'b1;
                    end else begin
                        n_above = 1'b1;
                    end
                end
                if (WC'(r_cnt) == w_nf_c - WC'(1)) begin
                    n_state = ST_DECIDE;
                end else begin
                    n_cnt = r_cnt + PW'(1);
                end
            end

            ST_DECIDE: begin
                n_two   = 1'b0;
                n_state = ST_EMIT0;
                unique case (r_mode)
                    MODE_UP: begin
                        if (!(r_at || r_above)) begin
                            n_mode = r_rev ? MODE_STOP : MODE_DOWN;
                            n_rev  = !r_rev;
                            n_res0 = mk_result(ACT_TURN, w_cf_cur, n_mode, 1'b1);
                        end else if (r_above) begin
                            n_rev = 1'b0;
                            if (w_can_up) begin
                                n_pos  = w_pos_up;
                                n_res1 = mk_result(ACT_MOVE, w_cf_up, MODE_UP, 1'b1);
                            end else begin
                                n_res1 = mk_result(ACT_MOVE, w_cf_cur, MODE_UP, 1'b1);
                            end
                            if (w_uc || w_cc) begin
                                n_car  = r_car & ~w_cmask;
                                n_up   = r_up & ~w_cmask;
                                n_res0 = mk_result(ACT_DOOR, w_cf_cur, MODE_UP, 1'b0);
                                n_two  = 1'b1;
                            end else begin
                                n_res0 = n_res1;
                            end
                        end else if (!w_uc) begin
                            // turn at the top call, then look downward
                            n_rev  = 1'b0;
                            n_mode = MODE_DOWN;
                            n_car  = r_car & ~w_cmask;
                            n_down = r_down & ~w_cmask;
                            n_res0 = mk_result(ACT_DOOR, w_cf_cur, MODE_DOWN, 1'b0);
                            n_two  = 1'b1;
                            if (!r_below) begin
                                n_mode = MODE_STOP;
                                n_res1 = mk_result(ACT_TURN, w_cf_cur, MODE_STOP, 1'b1);
                            end else if (!w_can_dn) begin
                                n_res1 = mk_result(ACT_IDLE, w_cf_cur, MODE_DOWN, 1'b1);
                            end else begin
                                n_pos  = w_pos_dn;
                                n_res1 = mk_result(ACT_MOVE, w_cf_dn, MODE_DOWN, 1'b1);
                            end
                        end else begin
                            n_rev = 1'b0;
                            n_car = r_car & ~w_cmask;
                            n_up  = r_up & ~w_cmask;
                            if (w_can_up) begin
                                n_pos  = w_pos_up;
                                n_res0 = mk_result(ACT_DOOR, w_cf_cur, MODE_UP, 1'b0);
                                n_res1 = mk_result(ACT_MOVE, w_cf_up, MODE_UP, 1'b1);
                                n_two  = 1'b1;
                            end else begin
                                n_res0 = mk_result(ACT_DOOR, w_cf_cur, MODE_UP, 1'b1);
                            end
                        end
                    end

                    MODE_DOWN: begin
                        if (!(r_below || r_at)) begin
                            n_mode = r_rev ? MODE_STOP : MODE_UP;
                            n_rev  = !r_rev;
                            n_res0 = mk_result(ACT_TURN, w_cf_cur, n_mode, 1'b1);
                        end else if (r_below) begin
                            n_rev = 1'b0;
                            if (w_can_dn) begin
                                n_pos  = w_pos_dn;
                                n_res1 = mk_result(ACT_MOVE, w_cf_dn, MODE_DOWN, 1'b1);
                            end else begin
                                n_res1 = mk_result(ACT_MOVE, w_cf_cur, MODE_DOWN, 1'b1);
                            end
                            if (w_dc || w_cc) begin
                                n_car  = r_car & ~w_cmask;
                                n_down = r_down & ~w_cmask;
                                n_res0 = mk_result(ACT_DOOR, w_cf_cur, MODE_DOWN, 1'b0);
                                n_two  = 1'b1;
                            end else begin
                                n_res0 = n_res1;
                            end
                        end else if (!w_dc) begin
                            // turn at the bottom call, then look upward
                            n_rev  = 1'b0;
                            n_mode = MODE_UP;
                            n_car  = r_car & ~w_cmask;
                            n_up   = r_up & ~w_cmask;
                            n_res0 = mk_result(ACT_DOOR, w_cf_cur, MODE_UP, 1'b0);
                            n_two  = 1'b1;
                            if (!r_above) begin
                                n_mode = MODE_STOP;
                                n_res1 = mk_result(ACT_TURN, w_cf_cur, MODE_STOP, 1'b1);
                            end else if (!w_can_up) begin
                                n_res1 = mk_result(ACT_IDLE, w_cf_cur, MODE_UP, 1'b1);
                            end else begin
                                n_pos  = w_pos_up;
                                n_res1 = mk_result(ACT_MOVE, w_cf_up, MODE_UP, 1'b1);
                            end
                        end else begin
                            n_rev  = 1'b0;
                            n_car  = r_car & ~w_cmask;
                            n_down = r_down & ~w_cmask;
                            if (w_can_dn) begin
                                n_pos  = w_pos_dn;
                                n_res0 = mk_result(ACT_DOOR, w_cf_cur, MODE_DOWN, 1'b0);
                                n_res1 = mk_result(ACT_MOVE, w_cf_dn, MODE_DOWN, 1'b1);
                                n_two  = 1'b1;
                            end else begin
                                n_res0 = mk_result(ACT_DOOR, w_cf_cur, MODE_DOWN, 1'b1);
                            end
                        end
                    end

                    default: begin
                        // stopped: head for the lowest call
                        if (!(r_below || r_at || r_above)) begin
                            n_res0 = mk_result(ACT_IDLE, w_cf_cur, r_mode, 1'b1);
                        end else begin
                            n_rev  = 1'b0;
                            n_mode = (!r_below && !r_at && r_above) ? MODE_UP : MODE_DOWN;
                            n_res0 = mk_result(ACT_TURN, w_cf_cur, n_mode, 1'b1);
                        end
                    end
                endcase
            end

            ST_EMIT0: begin
                o_res_push = !i_res_full;
                if (!i_res_full) begin
                    n_state = r_two ? ST_EMIT1 : ST_IDLE;
                end
            end

            ST_EMIT1: begin
                o_res_push = !i_res_full;
                if (!i_res_full) begin
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_num_floors <= NUM_FLOORS_RESET;
            r_up         <= '0;
            r_down       <= '0;
            r_car        <= '0;
            r_pos        <= '0;
            r_mode       <= MODE_STOP;
            r_rev        <= 1'b0;
        end else begin
            r_state <= n_state;
            r_up    <= n_up;
            r_down  <= n_down;
            r_car   <= n_car;
            r_pos   <= n_pos;
            r_mode  <= n_mode;
            r_rev   <= n_rev;
            if (i_cfg_valid) begin
                r_num_floors <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt   <= n_cnt;
        r_below <= n_below;
        r_at    <= n_at;
        r_above <= n_above;
        r_res0  <= n_res0;
        r_res1  <= n_res1;
        r_two   <= n_two;
    end

endmodule

FILE: src/elevator_sweep_controller.sv
// top level of the single-car sweep elevator controller
// depends on esc_pkg, esc_front, esc_back and esc_outq
//
// usage:
// - input side is a queue: drive i_op / i_floor with push; a beat is taken
//   at a rising edge with push high and full low. ops are hall up call,
//   hall down call, car call and tick
// - result side is a queue: while empty is low the oldest result sits on
//   o_action / o_car_floor / o_direction / o_last; pop takes it
// - a request gives one result; a tick gives one or two, o_last marks the
//   final one of the beat
// - num_floors is written over the cfg channel (valid / ready, ready is
//   always high); write it only while the block is idle
// - back part: a request beat passes the idle state and the first emit state;
//   a tick passes the floor scan, the decision state and the first emit
//   state, then the second one for a second result. the floor scan walks
//   one floor per cycle over the clamped floor count
// - a two-entry input queue lets the next beats in while the back part
//   scans; a two-entry result queue holds results while pop is low, and the
//   back part simply waits when it is full
// - reset (synchronous, active low) clears all calls, puts the car at floor
//   zero in stop mode, sets num_floors to 16 and empties both queues
module elevator_sweep_controller
    import esc_pkg::*;
#(
    parameter int FLOORS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [OP_W-1:0]    i_op,
    input  logic [FLOOR_W-1:0] i_floor,
    input  logic               pop,
    output logic               empty,
    output logic [ACT_W-1:0]   o_action,
    output logic [FLOOR_W-1:0] o_car_floor,
    output logic [MODE_W-1:0]  o_direction,
    output logic               o_last,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CFG_W-1:0]   i_cfg_data
);

    // front to back item beat
    logic    w_item_valid;
    t_item   w_item;
    logic    w_item_pop;

    // back to result queue
    logic    w_res_push;
    t_result w_res;
    logic    w_res_full;
    t_result w_res_head;

    esc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_op    (i_op),
        .i_floor (i_floor),
        .o_valid (w_item_valid),
        .o_item  (w_item),
        .i_pop   (w_item_pop)
    );

    esc_back #(
        .FLOORS (FLOORS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .o_item_pop   (w_item_pop),
        .i_res_full   (w_res_full),
        .o_res_push   (w_res_push),
        .o_res        (w_res)
    );

    esc_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_res   (w_res),
        .o_full  (w_res_full),
        .o_empty (empty),
        .o_res   (w_res_head),
        .i_pop   (pop)
    );

    // result head onto the ports
    assign o_action    = w_res_head.action;
    assign o_car_floor = w_res_head.car_floor;
    assign o_direction = w_res_head.direction;
    assign o_last      = w_res_head.last;

endmodule

FILE: src/esc_checker.sv
// port-level checks for the elevator sweep controller, bound to the top level
// depends on esc_pkg and assert_macros.svh
`include "assert_macros.svh"

module esc_checker
    import esc_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               pop,
    input logic               empty,
    input logic [ACT_W-1:0]   o_action,
    input logic [FLOOR_W-1:0] o_car_floor,
    input logic [MODE_W-1:0]  o_direction,
    input logic               o_last
);

    // result queue comes out of reset empty
    `ESC_ASSERT_ALWAYS(a_empty_after_reset, i_clk, !i_rst_n |=> empty, "results after reset")

    // a stalled result holds
    `ESC_ASSERT(a_hold_on_stall, i_clk, i_rst_n, (!empty && !pop) |=> (!empty && $stable(o_action) && $stable(o_car_floor) && $stable(o_direction) && $stable(o_last)), "result changed under stall")

    // idle and turn results always close their beat
    `ESC_ASSERT(a_idle_turn_last, i_clk, i_rst_n, (!empty && (o_action == ACT_IDLE || o_action == ACT_TURN)) |-> o_last, "idle or turn result not last")

    // a move happens only in up or down mode
    `ESC_ASSERT(a_move_has_dir, i_clk, i_rst_n, (!empty && o_action == ACT_MOVE) |-> (o_direction == MODE_UP || o_direction == MODE_DOWN), "move without direction")

endmodule

bind elevator_sweep_controller esc_checker u_esc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .pop         (pop),
    .empty       (empty),
    .o_action    (o_action),
    .o_car_floor (o_car_floor),
    .o_direction (o_direction),
    .o_last      (o_last)
);
